>>> src/a128cfb_pkg.sv
package a128cfb_pkg;

  localparam int DataW   = 8;
  localparam int BlockW  = 128;
  localparam int CfgW    = 64;
  localparam int CfgIdxW = 3;
  localparam int QDepth  = 4;
  localparam int Rounds  = 10;

  localparam logic [CfgIdxW-1:0] REG_KEY_HIGH  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_KEY_LOW   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_IV_HIGH   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_IV_LOW    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_DIRECTION = 3'd4;

  typedef struct packed {
    logic [DataW-1:0] data;
    logic             start;
  } item_t;

  typedef struct packed {
    logic              start;
    logic [BlockW-1:0] block;
    logic [BlockW-1:0] key;
  } aes_req_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] v);
    xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

endpackage

>>> src/a128cfb_front.sv
module a128cfb_front #(
  parameter int Depth = a128cfb_pkg::QDepth
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  a128cfb_pkg::item_t   in_item,
  output logic                 full,
  output logic                 q_valid,
  output a128cfb_pkg::item_t   q_item,
  input  logic                 q_pop
);
  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  a128cfb_pkg::item_t mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] cnt_r;
  logic            do_push, do_pop;

  assign full    = (cnt_r == CntW'(Depth));
  assign q_valid = (cnt_r != '0);
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;
  assign q_item  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + CntW'(do_push) - CntW'(do_pop);
    end
  end
endmodule

>>> src/a128cfb_aes.sv
module a128cfb_aes (
  input  logic                   clk,
  input  logic                   rst_n,
  input  a128cfb_pkg::aes_req_t  req,
  output logic                   done,
  output logic [a128cfb_pkg::BlockW-1:0] result
);
  logic [127:0] st_r, rk_r, rk_next, st_next;
  logic [7:0]   rc_r;
  logic [3:0]   rnd_r;
  logic         busy_r, done_r;
  logic [31:0]  w3, rot, sw, t;
  logic [7:0]   s  [16];
  logic [7:0]   sb [16];
  logic [7:0]   mx [16];
  logic [7:0]   a0, a1, a2, a3, all;
  logic         last;

  always_comb begin
    w3  = rk_r[31:0];
    rot = {w3[23:0], w3[31:24]};
    sw  = {a128cfb_pkg::SBOX[rot[31:24]], a128cfb_pkg::SBOX[rot[23:16]],
           a128cfb_pkg::SBOX[rot[15:8]], a128cfb_pkg::SBOX[rot[7:0]]};
    t   = sw ^ {rc_r, 24'h0};
    rk_next[127:96] = rk_r[127:96] ^ t;
    rk_next[95:64]  = rk_r[95:64] ^ rk_next[127:96];
    rk_next[63:32]  = rk_r[63:32] ^ rk_next[95:64];
    rk_next[31:0]   = rk_r[31:0] ^ rk_next[63:32];
  end

  always_comb begin
    last = (rnd_r == 4'(a128cfb_pkg::Rounds));
    a0 = '0; a1 = '0; a2 = '0; a3 = '0; all = '0;
    for (int i = 0; i < 16; i++) begin
      s[i] = st_r[127-8*i -: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sb[r+4*c] = a128cfb_pkg::SBOX[s[r + 4*((c + r) & 3)]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0  = sb[4*c];
      a1  = sb[4*c+1];
      a2  = sb[4*c+2];
      a3  = sb[4*c+3];
      all = a0 ^ a1 ^ a2 ^ a3;
      mx[4*c]   = a0 ^ all ^ a128cfb_pkg::xtime(a0 ^ a1);
      mx[4*c+1] = a1 ^ all ^ a128cfb_pkg::xtime(a1 ^ a2);
      mx[4*c+2] = a2 ^ all ^ a128cfb_pkg::xtime(a2 ^ a3);
      mx[4*c+3] = a3 ^ all ^ a128cfb_pkg::xtime(a3 ^ a0);
    end
    for (int i = 0; i < 16; i++) begin
      st_next[127-8*i -: 8] = (last ? sb[i] : mx[i]) ^ rk_next[127-8*i -: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      st_r <= req.block ^ req.key;
      rk_r <= req.key;
      rc_r <= 8'h01;
    end else if (busy_r) begin
      st_r <= st_next;
      rk_r <= rk_next;
      rc_r <= a128cfb_pkg::xtime(rc_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      rnd_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        rnd_r  <= 4'd1;
      end else if (busy_r) begin
        rnd_r <= rnd_r + 4'd1;
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done   = done_r;
  assign result = st_r;
endmodule

>>> src/a128cfb_back.sv
module a128cfb_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  a128cfb_pkg::item_t     q_item,
  output logic                   q_pop,
  input  logic [a128cfb_pkg::BlockW-1:0] key,
  input  logic [a128cfb_pkg::BlockW-1:0] iv,
  input  logic                   dir,
  output logic                   empty,
  input  logic                   pop,
  output logic [a128cfb_pkg::DataW-1:0] out_byte
);
  localparam logic S_IDLE = 1'b0;
  localparam logic S_AES  = 1'b1;

  logic       state_r, state_nxt;
  logic [7:0] fb_r [16];
  logic [7:0] ks_r [16];
  logic [7:0] fb_eff [16];
  logic [3:0] pos_r, pos_eff;
  logic       ivl_r, ivl_eff, ks_fresh_r;
  logic       out_valid_r;
  logic [7:0] out_byte_r, res, fb_new;
  logic       out_free, work, need_aes, out_load;
  logic [127:0] fb_flat;
  a128cfb_pkg::aes_req_t req;
  logic       aes_done;
  logic [127:0] aes_out;

  assign out_free = !out_valid_r || pop;
  assign work     = (state_r == S_IDLE) && q_valid && out_free;
  assign pos_eff  = q_item.start ? 4'd0 : pos_r;
  assign ivl_eff  = q_item.start ? dir : ivl_r;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      fb_eff[i]            = (q_item.start && !dir) ? iv[127-8*i -: 8] : fb_r[i];
      fb_flat[127-8*i -: 8] = fb_eff[i];
    end
  end

  assign need_aes  = !ivl_eff && (pos_eff == 4'd0) && !ks_fresh_r;
  assign q_pop     = work && !need_aes;
  assign out_load  = q_pop && !ivl_eff;
  assign res       = q_item.data ^ ks_r[pos_eff];
  assign fb_new    = (ivl_eff || dir) ? q_item.data : res;
  assign req.start = work && need_aes;
  assign req.block = fb_flat;
  assign req.key   = key;

  a128cfb_aes u_aes (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .done   (aes_done),
    .result (aes_out)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (req.start) state_nxt = S_AES;
      S_AES:  if (aes_done) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      ivl_r       <= 1'b0;
      ks_fresh_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        fb_r[i] <= '0;
        ks_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
      if (aes_done) begin
        ks_fresh_r <= 1'b1;
        for (int i = 0; i < 16; i++) begin
          ks_r[i] <= aes_out[127-8*i -: 8];
        end
      end
      if (req.start) begin
        fb_r  <= fb_eff;
        pos_r <= pos_eff;
        ivl_r <= ivl_eff;
      end else if (q_pop) begin
        for (int i = 0; i < 16; i++) begin
          fb_r[i] <= (4'(i) == pos_eff) ? fb_new : fb_eff[i];
        end
        pos_r      <= pos_eff + 4'd1;
        ivl_r      <= ivl_eff && (pos_eff != 4'd15);
        ks_fresh_r <= 1'b0;
      end
    end
  end

  assign empty    = !out_valid_r;
  assign out_byte = out_byte_r;

  a_no_pop_in_aes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_AES) |-> !q_pop) else $error("item taken during cipher run");
  a_done_in_aes: assert property (@(posedge clk) disable iff (!rst_n)
    aes_done |-> (state_r == S_AES)) else $error("cipher done outside run");
  a_load_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && ivl_eff) |=> !(out_valid_r && !$past(out_valid_r)))
    else $error("iv byte produced a result");
  a_fresh_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    aes_done |=> ks_fresh_r && (state_r == S_IDLE)) else $error("keystream not marked");
endmodule

>>> src/aes128_cfb_byte_cipher_core.sv
// a byte mid-block passes the queue and the output register from push to empty low
// a byte at a block boundary first waits for a run of the 10-round iterative aes unit
// throughput: one byte per cycle inside a block while pop keeps the output register free
// the aes round loop holds each block boundary; feedback forbids overlap of blocks
// reset: synchronous active-low rst_n clears queue, feedback, keystream, config
module aes128_cfb_byte_cipher_core #(
  parameter int QueueDepth = a128cfb_pkg::QDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_message_start,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_result_byte,
  input  logic        cfg_we,
  input  logic [a128cfb_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [a128cfb_pkg::CfgW-1:0]    cfg_data
);
  logic [63:0] key_high_r, key_low_r, iv_high_r, iv_low_r;
  logic        dir_r;
  a128cfb_pkg::item_t in_item, q_item;
  logic        q_valid, q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
      iv_high_r  <= '0;
      iv_low_r   <= '0;
      dir_r      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        a128cfb_pkg::REG_KEY_HIGH:  key_high_r <= cfg_data;
        a128cfb_pkg::REG_KEY_LOW:   key_low_r  <= cfg_data;
        a128cfb_pkg::REG_IV_HIGH:   iv_high_r  <= cfg_data;
        a128cfb_pkg::REG_IV_LOW:    iv_low_r   <= cfg_data;
        a128cfb_pkg::REG_DIRECTION: dir_r      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_item.data  = in_data_byte;
  assign in_item.start = in_message_start;

  a128cfb_front #(.Depth(QueueDepth)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .in_item (in_item),
    .full    (full),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  a128cfb_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .key      ({key_high_r, key_low_r}),
    .iv       ({iv_high_r, iv_low_r}),
    .dir      (dir_r),
    .empty    (empty),
    .pop      (pop),
    .out_byte (out_result_byte)
  );
endmodule
